// ----- rtl/stepper_driver_spi_and_step_counter_top_macros.svh -----
// assertion macros for the stepper driver spi and step counter block
`ifndef STEPPER_DRIVER_SPI_AND_STEP_COUNTER_TOP_MACROS_SVH
`define STEPPER_DRIVER_SPI_AND_STEP_COUNTER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SDSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SDSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sdsc_pkg.sv -----
// shared types and constants for the stepper driver spi and step counter block
`timescale 1ns / 1ps

package sdsc_pkg;

  localparam int REG_COUNT_DEF = 128;
  localparam int ADDR_W        = 7;
  localparam int DG_W          = 40;
  localparam int MAX_POS_W     = 24;
  localparam int CFG_IDX_W     = 2;

  localparam logic [ADDR_W-1:0]    ADDR_GSTAT         = 7'h01;
  localparam logic [ADDR_W-1:0]    ADDR_DRV_STATUS    = 7'h6F;
  localparam logic [31:0]          STALL_RESULT_RESET = 32'd250;
  localparam logic [MAX_POS_W-1:0] MAX_POSITION_RESET = 24'd25500;
  localparam int                   DRV_STALL_BIT      = 24;
  localparam int                   DRV_STST_BIT       = 31;

  typedef enum logic [2:0] {
    OP_SPI_BYTE    = 3'd0,
    OP_CHIP_SELECT = 3'd1,
    OP_STEP        = 3'd2,
    OP_DIRECTION   = 3'd3,
    OP_ENABLE      = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_POSITION   = 2'd0,
    CFG_LIMITS_ENABLED = 2'd1,
    CFG_DIR_INVERT     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               spi_byte_valid;
    logic [7:0]         spi_byte;
    logic               position_valid;
    logic signed [31:0] position;
    logic               diag_valid;
    logic               diag_level;
  } res_t;

endpackage

// ----- rtl/stepper_driver_spi_and_step_counter_top.sv -----
// stepper driver pin model: spi datagram register interface and step counter
// each result word is registered into out_* as its word is accepted, or into the skid while out_* waits
// throughput: one word per cycle while the skid word is empty; every word is handled in a single registered pass
// a two-entry output (result register plus skid) keeps input flowing while one result waits
// reset (rst_n low, synchronous): control state and config to defaults, register file
// valid bits cleared so every entry but DRV_STATUS reads zero; no clearing pass, ready right after reset
`timescale 1ns / 1ps

`include "stepper_driver_spi_and_step_counter_top_macros.svh"

module stepper_driver_spi_and_step_counter_top #(
  parameter int REG_COUNT = sdsc_pkg::REG_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_operation,
  input  logic [7:0]                     in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_spi_byte_valid,
  output logic [7:0]                     out_spi_byte,
  output logic                           out_position_valid,
  output logic signed [31:0]             out_position,
  output logic                           out_diag_valid,
  output logic                           out_diag_level,
  input  logic                           cfg_we,
  input  logic [sdsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdsc_pkg::MAX_POS_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(REG_COUNT);
  localparam bit DRV_IN_RANGE = (REG_COUNT > int'(sdsc_pkg::ADDR_DRV_STATUS));
  localparam logic [31:0] DRV_RESET = DRV_IN_RANGE ? sdsc_pkg::STALL_RESULT_RESET : 32'd0;

  // control and pin state
  logic                               sel_r, sel_nxt;
  logic                               dir_r, dir_nxt;
  logic                               en_r, en_nxt;
  logic                               step_lvl_r, step_lvl_nxt;
  logic [31:0]                        pos_r, pos_nxt;
  logic [sdsc_pkg::DG_W-1:0]          dg_r, dg_nxt;
  logic [sdsc_pkg::DG_W-1:0]          rep_r, rep_nxt;
  logic [31:0]                        gstat_r, gstat_nxt;
  logic [31:0]                        drv_r, drv_nxt;

  // configuration
  logic [sdsc_pkg::MAX_POS_W-1:0]     max_pos_r;
  logic                               lim_en_r;
  logic                               dir_inv_r;

  // register file
  logic [31:0]                        mem [REG_COUNT];
  logic [REG_COUNT-1:0]               vld_r;
  logic [31:0]                        rd_data_r;
  logic                               rd_vld_r;
  logic                               mem_we;
  logic [IDX_W-1:0]                   wr_idx;
  logic [IDX_W-1:0]                   rd_idx;
  logic                               bypass;

  // output stage
  logic                               out_valid_r;
  sdsc_pkg::res_t                     out_r;
  logic                               skid_valid_r;
  sdsc_pkg::res_t                     skid_r;
  sdsc_pkg::res_t                     res;

  logic                               push;
  logic                               lvl;
  sdsc_pkg::op_t                      op;
  logic                               dg_wr;
  logic [sdsc_pkg::ADDR_W-1:0]        dg_addr;
  logic [31:0]                        dg_data;
  logic                               addr_in_range;
  logic [31:0]                        body;
  logic [31:0]                        gstat_new;
  logic [31:0]                        drv_new;
  logic [3:0]                         status;
  logic [31:0]                        max_ext;
  logic [31:0]                        pos_inc;
  logic [31:0]                        pos_lim;
  logic                               stall;
  logic                               step_take;

  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign lvl      = in_value[0];
  assign op       = sdsc_pkg::op_t'(in_operation);

  // datagram fields
  assign dg_wr         = dg_r[39];
  assign dg_addr       = dg_r[38:32];
  assign dg_data       = dg_r[31:0];
  assign addr_in_range = (int'(dg_addr) < REG_COUNT);
  assign wr_idx        = dg_addr[IDX_W-1:0];

  // status after a possible write at this chip select edge
  assign gstat_new = (mem_we && (dg_addr == sdsc_pkg::ADDR_GSTAT)) ? dg_data : gstat_r;
  assign drv_new   = (mem_we && DRV_IN_RANGE && (dg_addr == sdsc_pkg::ADDR_DRV_STATUS)) ?
                     dg_data : drv_r;
  assign status    = {drv_new[sdsc_pkg::DRV_STST_BIT], drv_new[sdsc_pkg::DRV_STALL_BIT],
                      gstat_new[1], gstat_new[0]};

  always_comb begin
    if (dg_wr) begin
      body = dg_data;
    end else if (dg_addr == sdsc_pkg::ADDR_GSTAT) begin
      body = gstat_r;
    end else if (DRV_IN_RANGE && (dg_addr == sdsc_pkg::ADDR_DRV_STATUS)) begin
      body = drv_r;
    end else if (addr_in_range && rd_vld_r) begin
      body = rd_data_r;
    end else begin
      body = 32'd0;
    end
  end

  // step arithmetic: one increment or decrement and, with limits enabled, a clamp to zero and max_position
  assign max_ext = {{(32 - sdsc_pkg::MAX_POS_W){1'b0}}, max_pos_r};
  assign pos_inc = dir_r ? (pos_r - 32'd1) : (pos_r + 32'd1);

  always_comb begin
    pos_lim = pos_inc;
    stall   = 1'b0;
    if (lim_en_r) begin
      if (pos_inc[31]) begin
        pos_lim = 32'd0;
        stall   = 1'b1;
      end else if (pos_inc > max_ext) begin
        pos_lim = max_ext;
        stall   = 1'b1;
      end
    end
  end

  assign step_take = push && (op == sdsc_pkg::OP_STEP) && lvl && !step_lvl_r && en_r;

  always_comb begin
    sel_nxt      = sel_r;
    dir_nxt      = dir_r;
    en_nxt       = en_r;
    step_lvl_nxt = step_lvl_r;
    pos_nxt      = pos_r;
    dg_nxt       = dg_r;
    rep_nxt      = rep_r;
    gstat_nxt    = gstat_r;
    drv_nxt      = drv_r;
    mem_we       = 1'b0;
    res          = '0;
    if (push) begin
      case (op)
        sdsc_pkg::OP_SPI_BYTE: begin
          if (sel_r) begin
            res.spi_byte_valid = 1'b1;
            res.spi_byte       = rep_r[39:32];
            rep_nxt            = {rep_r[31:0], 8'h00};
            dg_nxt             = {dg_r[31:0], in_value};
          end
        end
        sdsc_pkg::OP_CHIP_SELECT: begin
          sel_nxt = !lvl;
          if (lvl && sel_r) begin
            mem_we    = dg_wr && addr_in_range;
            gstat_nxt = gstat_new;
            drv_nxt   = drv_new;
            rep_nxt   = {4'h0, status, body};
          end
        end
        sdsc_pkg::OP_STEP: begin
          step_lvl_nxt = lvl;
          if (step_take) begin
            pos_nxt            = pos_lim;
            res.position_valid = 1'b1;
            if (stall) begin
              res.diag_valid = 1'b1;
              res.diag_level = 1'b1;
            end else if (drv_r[sdsc_pkg::DRV_STALL_BIT]) begin
              res.diag_valid = 1'b1;
            end
            if (DRV_IN_RANGE) begin
              drv_nxt[sdsc_pkg::DRV_STALL_BIT] = stall;
            end
          end
        end
        sdsc_pkg::OP_DIRECTION: begin
          dir_nxt = lvl ^ dir_inv_r;
        end
        sdsc_pkg::OP_ENABLE: begin
          en_nxt = !lvl;
        end
        default: begin
        end
      endcase
    end
    res.position = pos_nxt;
  end

  // read port follows the next datagram address; same-edge write is forwarded
  assign rd_idx = dg_nxt[32 +: IDX_W];
  assign bypass = mem_we && (wr_idx == rd_idx);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= dg_data;
    end
    rd_data_r <= bypass ? dg_data : mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[wr_idx] <= 1'b1;
      end
      rd_vld_r <= bypass || vld_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r      <= 1'b0;
      dir_r      <= 1'b0;
      en_r       <= 1'b0;
      step_lvl_r <= 1'b0;
      pos_r      <= 32'd0;
      dg_r       <= '0;
      rep_r      <= '0;
      gstat_r    <= 32'd0;
      drv_r      <= DRV_RESET;
    end else begin
      sel_r      <= sel_nxt;
      dir_r      <= dir_nxt;
      en_r       <= en_nxt;
      step_lvl_r <= step_lvl_nxt;
      pos_r      <= pos_nxt;
      dg_r       <= dg_nxt;
      rep_r      <= rep_nxt;
      gstat_r    <= gstat_nxt;
      drv_r      <= drv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pos_r <= sdsc_pkg::MAX_POSITION_RESET;
      lim_en_r  <= 1'b1;
      dir_inv_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdsc_pkg::CFG_MAX_POSITION:   max_pos_r <= cfg_data;
        sdsc_pkg::CFG_LIMITS_ENABLED: lim_en_r  <= cfg_data[0];
        sdsc_pkg::CFG_DIR_INVERT:     dir_inv_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // result register with skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_spi_byte_valid = out_r.spi_byte_valid;
  assign out_spi_byte       = out_r.spi_byte;
  assign out_position_valid = out_r.position_valid;
  assign out_position       = out_r.position;
  assign out_diag_valid     = out_r.diag_valid;
  assign out_diag_level     = out_r.diag_level;

  `SDSC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
                   "skid word without result word")
  `SDSC_ASSERT_NOW(a_clamp_bounds, step_take && lim_en_r,
                   !pos_nxt[31] && (pos_nxt <= max_ext), "position outside limits")
  `SDSC_ASSERT_NOW(a_diag_needs_step, res.diag_valid, res.position_valid,
                   "diag driven without step")
  `SDSC_ASSERT_NEXT(a_write_forward, bypass, rd_vld_r && (rd_data_r == $past(dg_data)),
                    "stale read after write")

endmodule

// ----- tb/stepper_driver_spi_and_step_counter_top_tb.sv -----
// testbench for the stepper driver spi and step counter block: directed and random words
`timescale 1ns / 1ps

module stepper_driver_spi_and_step_counter_top_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_WORDS = 100;
  localparam int NUM_PHASES  = 7;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // mirror of the pin-side behavior; holds the result words still owed by the block
  class pin_side_mirror;
    logic [31:0]                    regs [0:sdsc_pkg::REG_COUNT_DEF-1];
    logic [sdsc_pkg::DG_W-1:0]      datagram;
    logic [sdsc_pkg::DG_W-1:0]      reply;
    logic                           selected;
    logic                           direction;
    logic                           enabled;
    logic                           last_step;
    logic                           limits_on;
    logic                           dir_inv;
    logic [31:0]                    position;
    logic [sdsc_pkg::MAX_POS_W-1:0] max_pos;
    sdsc_pkg::res_t                 owed_words[$];
    int                             fails;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[sdsc_pkg::ADDR_DRV_STATUS] = sdsc_pkg::STALL_RESULT_RESET;
      datagram  = '0;
      reply     = '0;
      selected  = 1'b0;
      direction = 1'b0;
      enabled   = 1'b0;
      last_step = 1'b0;
      position  = '0;
      max_pos   = sdsc_pkg::MAX_POSITION_RESET;
      limits_on = 1'b1;
      dir_inv   = 1'b0;
      fails     = 0;
    endfunction

    function void set_reg(sdsc_pkg::cfg_idx_t idx, logic [sdsc_pkg::MAX_POS_W-1:0] d);
      case (idx)
        sdsc_pkg::CFG_MAX_POSITION:   max_pos = d;
        sdsc_pkg::CFG_LIMITS_ENABLED: limits_on = d[0];
        sdsc_pkg::CFG_DIR_INVERT:     dir_inv = d[0];
        default: ;
      endcase
    endfunction

    // chip select rose: decode the datagram and build the next reply
    function void close_datagram();
      logic [sdsc_pkg::ADDR_W-1:0] addr;
      logic [31:0]                 body;
      logic [31:0]                 gstat;
      logic [31:0]                 drv;
      addr = datagram[38:32];
      if (datagram[39]) regs[addr] = datagram[31:0];
      body  = datagram[39] ? datagram[31:0] : regs[addr];
      gstat = regs[sdsc_pkg::ADDR_GSTAT];
      drv   = regs[sdsc_pkg::ADDR_DRV_STATUS];
      reply = {4'b0000, drv[sdsc_pkg::DRV_STST_BIT], drv[sdsc_pkg::DRV_STALL_BIT],
               gstat[1], gstat[0], body};
    endfunction

    function void accept_word(logic [2:0] op, logic [7:0] val);
      sdsc_pkg::res_t r;
      logic lvl;
      logic stall;
      logic prev_stall;
      r   = '0;
      lvl = val[0];
      case (op)
        sdsc_pkg::OP_SPI_BYTE: begin
          if (selected) begin
            r.spi_byte_valid = 1'b1;
            r.spi_byte       = reply[39:32];
            reply            = {reply[31:0], 8'h00};
            datagram         = {datagram[31:0], val};
          end
        end
        sdsc_pkg::OP_CHIP_SELECT: begin
          if (lvl && selected) close_datagram();
          selected = !lvl;
        end
        sdsc_pkg::OP_STEP: begin
          if (lvl && !last_step && enabled) begin
            prev_stall = regs[sdsc_pkg::ADDR_DRV_STATUS][sdsc_pkg::DRV_STALL_BIT];
            stall      = 1'b0;
            position   = direction ? position - 32'd1 : position + 32'd1;
            if (limits_on && position[31]) begin
              position = '0;
              stall    = 1'b1;
            end else if (limits_on && position > {8'h00, max_pos}) begin
              position = {8'h00, max_pos};
              stall    = 1'b1;
            end
            r.position_valid = 1'b1;
            r.diag_valid     = stall | prev_stall;
            r.diag_level     = stall;
            regs[sdsc_pkg::ADDR_DRV_STATUS][sdsc_pkg::DRV_STALL_BIT] = stall;
          end
          last_step = lvl;
        end
        sdsc_pkg::OP_DIRECTION: direction = lvl ^ dir_inv;
        sdsc_pkg::OP_ENABLE:    enabled = !lvl;
        default: ;
      endcase
      r.position = position;
      owed_words.push_back(r);
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
        fails++;
      end
    endfunction

    function void check_word(sdsc_pkg::res_t got);
      sdsc_pkg::res_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: result word with none expected, actual %0h", $time, got);
        fails++;
        return;
      end
      want = owed_words.pop_front();
      compare_field("spi_byte_valid", 32'(want.spi_byte_valid), 32'(got.spi_byte_valid));
      compare_field("spi_byte", 32'(want.spi_byte), 32'(got.spi_byte));
      compare_field("position_valid", 32'(want.position_valid), 32'(got.position_valid));
      compare_field("position", want.position, got.position);
      compare_field("diag_valid", 32'(want.diag_valid), 32'(got.diag_valid));
      compare_field("diag_level", 32'(want.diag_level), 32'(got.diag_level));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [2:0]                     in_operation = '0;
  logic [7:0]                     in_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_spi_byte_valid;
  logic [7:0]                     out_spi_byte;
  logic                           out_position_valid;
  logic signed [31:0]             out_position;
  logic                           out_diag_valid;
  logic                           out_diag_level;
  logic                           cfg_we = 1'b0;
  logic [sdsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sdsc_pkg::MAX_POS_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;

  pin_side_mirror mirror = new();

  stepper_driver_spi_and_step_counter_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_spi_byte_valid (out_spi_byte_valid),
    .out_spi_byte       (out_spi_byte),
    .out_position_valid (out_position_valid),
    .out_position       (out_position),
    .out_diag_valid     (out_diag_valid),
    .out_diag_level     (out_diag_level),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // notes accepted words, checks results, and ends the run if nothing moves
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      quiet++;
      if (rst_n && in_valid && in_ready) begin
        mirror.accept_word(in_operation, in_value);
        quiet = 0;
      end
      if (rst_n && out_valid && out_ready) begin
        mirror.check_word(sdsc_pkg::res_t'({out_spi_byte_valid, out_spi_byte,
                                            out_position_valid, out_position,
                                            out_diag_valid, out_diag_level}));
        quiet = 0;
      end
    end
    $display("stepper_driver_spi_and_step_counter_top verification failed");
    $finish;
  end

  function automatic logic [7:0] pin_word(logic lvl);
    logic [7:0] v;
    v    = 8'($urandom);
    v[0] = lvl;
    return v;
  endfunction

  task send_word(logic [2:0] op, logic [7:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_value     = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // stop sending and let every owed word come back before touching config
  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.owed_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(sdsc_pkg::cfg_idx_t idx, logic [sdsc_pkg::MAX_POS_W-1:0] d);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    mirror.set_reg(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task load_limits(logic [sdsc_pkg::MAX_POS_W-1:0] top, logic lim, logic inv);
    write_reg(sdsc_pkg::CFG_MAX_POSITION, top);
    write_reg(sdsc_pkg::CFG_LIMITS_ENABLED, sdsc_pkg::MAX_POS_W'(lim));
    write_reg(sdsc_pkg::CFG_DIR_INVERT, sdsc_pkg::MAX_POS_W'(inv));
  endtask

  task run_directed();
    send_word(sdsc_pkg::OP_SPI_BYTE, 8'hFF);      // deselected, no reply byte
    send_word(sdsc_pkg::OP_CHIP_SELECT, 8'h01);   // high while already high
    send_word(sdsc_pkg::OP_STEP, 8'h01);          // disabled, level only
    send_word(sdsc_pkg::OP_ENABLE, 8'hFE);
    send_word(sdsc_pkg::OP_DIRECTION, 8'h01);
    send_word(sdsc_pkg::OP_STEP, 8'h00);
    send_word(sdsc_pkg::OP_STEP, 8'hFF);          // below zero: clamp and stall
    send_word(sdsc_pkg::OP_DIRECTION, 8'h00);
    send_word(sdsc_pkg::OP_STEP, 8'h00);
    send_word(sdsc_pkg::OP_STEP, 8'h01);          // clean step after stall drives diag low
    send_word(sdsc_pkg::OP_CHIP_SELECT, 8'h00);
    send_word(sdsc_pkg::OP_SPI_BYTE, {1'b1, sdsc_pkg::ADDR_DRV_STATUS});
    send_word(sdsc_pkg::OP_SPI_BYTE, 8'h81);      // stall and standstill bits
    send_word(sdsc_pkg::OP_SPI_BYTE, 8'h00);
    send_word(sdsc_pkg::OP_SPI_BYTE, 8'h00);
    send_word(sdsc_pkg::OP_SPI_BYTE, 8'h00);
    send_word(sdsc_pkg::OP_CHIP_SELECT, 8'h01);
    send_word(sdsc_pkg::OP_CHIP_SELECT, 8'h00);
    send_word(sdsc_pkg::OP_SPI_BYTE, {1'b0, sdsc_pkg::ADDR_GSTAT});
    send_word(sdsc_pkg::OP_SPI_BYTE, 8'hFF);      // short datagram
    send_word(sdsc_pkg::OP_CHIP_SELECT, 8'hFF);
    send_word(sdsc_pkg::OP_STEP, 8'h00);
    send_word(sdsc_pkg::OP_STEP, 8'h01);
    send_word(OP_UNUSED, 8'hAA);
    send_word(sdsc_pkg::OP_ENABLE, 8'h01);
  endtask

  task spi_frame();
    logic [sdsc_pkg::ADDR_W-1:0] addr;
    int nb;
    case ($urandom_range(3))
      0:       addr = sdsc_pkg::ADDR_GSTAT;
      1:       addr = sdsc_pkg::ADDR_DRV_STATUS;
      2:       addr = sdsc_pkg::ADDR_W'($urandom_range(7));
      default: addr = sdsc_pkg::ADDR_W'($urandom);
    endcase
    nb = ($urandom_range(7) == 0) ? $urandom_range(1, 8) : 5;
    if ($urandom_range(15) != 0) send_word(sdsc_pkg::OP_CHIP_SELECT, pin_word(1'b0));
    send_word(sdsc_pkg::OP_SPI_BYTE, {1'($urandom_range(1)), addr});
    for (int k = 1; k < nb; k++) send_word(sdsc_pkg::OP_SPI_BYTE, 8'($urandom_range(255)));
    if ($urandom_range(15) != 0) send_word(sdsc_pkg::OP_CHIP_SELECT, pin_word(1'b1));
  endtask

  task step_burst();
    int n;
    n = $urandom_range(1, 12);
    if ($urandom_range(3) == 0)
      send_word(sdsc_pkg::OP_ENABLE, pin_word($urandom_range(4) == 0));
    if ($urandom_range(1) == 1)
      send_word(sdsc_pkg::OP_DIRECTION, pin_word(1'($urandom_range(1))));
    repeat (n) begin
      send_word(sdsc_pkg::OP_STEP, pin_word(1'b1));
      if ($urandom_range(7) != 0) send_word(sdsc_pkg::OP_STEP, pin_word(1'b0));
    end
  endtask

  task random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      spi_frame();
    end else if (pick < 85) begin
      step_burst();
    end else begin
      repeat ($urandom_range(1, 4))
        send_word(3'($urandom_range(7)), 8'($urandom_range(255)));
    end
  endtask

  task phase_setup(int p);
    case (p % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 49;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 49;
      end
      default: begin
        send_idle_pct  = 9;
        recv_stall_pct = 9;
      end
    endcase
    case (p)
      0: ;  // values from reset
      1: load_limits('0, 1'b1, 1'b0);
      2: load_limits(sdsc_pkg::MAX_POS_W'($urandom_range(3, 20)), 1'b1, 1'b1);
      3: load_limits('1, 1'b0, 1'b0);   // free wrap, position may go negative
      4: load_limits(sdsc_pkg::MAX_POS_W'($urandom_range(1, 40)), 1'b1, 1'b1);
      5: load_limits('1, 1'b1, 1'b0);
      default: load_limits(sdsc_pkg::MAX_POS_W'($urandom_range(0, 30)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
    endcase
  endtask

  initial begin
    int start;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      phase_setup(p);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) random_sequence();
    end
    drain();
    if (mirror.fails == 0 && mirror.owed_words.size() == 0) begin
      $display("stepper_driver_spi_and_step_counter_top verification clean");
    end else begin
      $display("stepper_driver_spi_and_step_counter_top verification failed");
    end
    $finish;
  end

endmodule
